/* src/lirs_pkg.sv */
// Package for the 44.1 kHz linear interpolation resampler.
// Holds widths, rate constants, payload types and the controller/datapath structs.
// No dependencies.
package lirs_pkg;

    localparam int unsigned OUT_RATE    = 44100;
    localparam int unsigned MAX_RES     = 26;
    localparam int unsigned RATE_MIN    = 4000;
    localparam int unsigned RATE_MAX    = 192000;
    localparam int unsigned RATE_RESET  = 16000;

    localparam int SAMPLE_W    = 16;
    localparam int RATE_W      = 18;
    localparam int COUNT_W     = 32;
    localparam int PHASE_W     = 16;
    localparam int RES_CNT_W   = 5;
    localparam int PROD_W      = 33;
    localparam int MAG_W       = 31;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 46;
    localparam int QUOT_W      = 16;
    localparam int ADV_Q_W     = 3;
    localparam int ADV_MAX_Q   = (OUT_RATE - 1 + RATE_MAX) / OUT_RATE;

    // floor(2^46 / 44100): the quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / OUT_RATE);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [RATE_W-1:0]          t_rate;
    typedef logic [COUNT_W-1:0]         t_count;
    typedef logic [PHASE_W-1:0]         t_phase;

    typedef struct packed {
        logic load_in;     // latch the accepted request
        logic catch_up;    // pull the output position up to the current pair
        logic start_calc;  // products and position advance
        logic sum;         // accumulate, magnitude, lookahead
        logic recip;       // reciprocal multiply
        logic corr;        // quotient correction and sign
        logic emit_calc;   // load output register, commit position
        logic emit_pass;   // load output register with the input sample
        logic finish;      // close out the request
        logic end_sel;     // current output repeats the last sample
        logic room_next;   // another result still fits after this one
    } t_dp_cmd;

    typedef struct packed {
        logic pass;
        logic interp_go;
        logic end_go;
        logic out_free;
    } t_dp_sts;

endpackage

/* src/lirs_ifs.sv */
// Channel interfaces for the resampler: input samples, output samples, rate register.
// Depends on lirs_pkg for the payload types.
interface lirs_in_if;
    logic              valid;
    logic              ready;
    lirs_pkg::t_sample sample_in;
    logic              in_last;
    modport source(output valid, sample_in, in_last, input ready);
    modport sink(input valid, sample_in, in_last, output ready);
endinterface

interface lirs_out_if;
    logic              valid;
    logic              ready;
    lirs_pkg::t_sample sample_out;
    logic              out_last;
    modport source(output valid, sample_out, out_last, input ready);
    modport sink(input valid, sample_out, out_last, output ready);
endinterface

interface lirs_cfg_if;
    logic            valid;
    logic            ready;
    lirs_pkg::t_rate source_rate;
    modport source(output valid, source_rate, input ready);
    modport sink(input valid, source_rate, output ready);
endinterface

/* src/lirs_ctrl.sv */
// Sequencer for the resampler: walks each request through setup, per-output
// evaluation, the arithmetic steps and emission. Depends on lirs_pkg.
module lirs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lirs_pkg::t_dp_sts i_sts,
    output lirs_pkg::t_dp_cmd o_cmd
);
    import lirs_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SETUP  = 4'd1;
    localparam logic [3:0] ST_EVAL   = 4'd2;
    localparam logic [3:0] ST_MUL    = 4'd3;
    localparam logic [3:0] ST_SUM    = 4'd4;
    localparam logic [3:0] ST_RECIP  = 4'd5;
    localparam logic [3:0] ST_CORR   = 4'd6;
    localparam logic [3:0] ST_EMIT   = 4'd7;
    localparam logic [3:0] ST_PASS   = 4'd8;
    localparam logic [3:0] ST_FINISH = 4'd9;

    logic [3:0]           r_state, n_state;
    logic [RES_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_end_phase, n_end_phase;
    logic                 room;

    assign room       = r_cnt < RES_CNT_W'(MAX_RES);
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_end_phase = r_end_phase;
        o_cmd           = '0;
        o_cmd.end_sel   = r_end_phase;
        o_cmd.room_next = (6'(r_cnt) + 6'd1) < 6'(MAX_RES);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_cnt         = '0;
                    n_end_phase   = 1'b0;
                    n_state       = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (i_sts.pass) begin
                    n_state = ST_PASS;
                end else begin
                    o_cmd.catch_up = 1'b1;
                    n_state        = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (room && !r_end_phase && i_sts.interp_go) begin
                    n_state = ST_MUL;
                end else if (room && i_sts.end_go) begin
                    // once the tail starts, interpolation is done for this request
                    n_end_phase = 1'b1;
                    n_state     = ST_MUL;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_MUL: begin
                o_cmd.start_calc = 1'b1;
                n_state          = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_RECIP;
            end
            ST_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = ST_CORR;
            end
            ST_CORR: begin
                o_cmd.corr = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_calc = 1'b1;
                    n_cnt           = r_cnt + RES_CNT_W'(1);
                    n_state         = ST_EVAL;
                end
            end
            ST_PASS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_pass = 1'b1;
                    n_state         = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_end_phase <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_end_phase <= n_end_phase;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RES_CNT_W'(MAX_RES))
        else $error("result count beyond limit");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_calc || o_cmd.emit_pass) |-> i_sts.out_free)
        else $error("output register loaded while occupied");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_in, o_cmd.emit_calc, o_cmd.emit_pass, o_cmd.finish}))
        else $error("conflicting datapath commands");

endmodule

/* src/lirs_dp.sv */
// Datapath for the resampler: stream state, position advance, interpolation
// with reciprocal division, and the output register. Depends on lirs_pkg.
module lirs_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  lirs_pkg::t_rate   i_cfg_rate,
    input  lirs_pkg::t_sample i_sample_in,
    input  logic              i_in_last,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output lirs_pkg::t_sample o_sample_out,
    output logic              o_out_last,
    input  lirs_pkg::t_dp_cmd i_cmd,
    output lirs_pkg::t_dp_sts o_sts
);
    import lirs_pkg::*;

    t_rate                  r_rate;
    t_sample                r_cur;
    logic                   r_last;
    t_sample                r_prev;
    t_count                 r_k;
    t_count                 r_whole;
    t_phase                 r_phase;
    logic signed [PROD_W-1:0] r_p0, r_p1;
    t_count                 r_adv_whole;
    t_phase                 r_adv_phase;
    logic [MAG_W-1:0]       r_mag;
    logic                   r_neg;
    logic [MAG_W+RECIP_W-1:0] r_prod;
    t_sample                r_interp;
    logic                   r_more;
    logic                   r_out_valid;
    t_sample                r_out_sample;
    logic                   r_out_last;

    t_rate                  rate_eff;
    t_count                 km1;
    t_count                 ahead;
    logic [RATE_W-1:0]      adv_sum;
    logic [ADV_Q_W-1:0]     adv_q;
    logic [RATE_W-1:0]      adv_sub;
    logic signed [PROD_W:0] acc;
    logic signed [PROD_W:0] acc_abs;
    logic [QUOT_W-1:0]      q0;
    logic [COUNT_W-1:0]     q0_back;
    logic [COUNT_W-1:0]     rem;
    logic [QUOT_W:0]        quot;
    logic                   more_interp;
    logic                   more_end;

    function automatic logic end_cond(input t_count d, input t_phase ph);
        end_cond = (d == '0) || ((d == COUNT_W'(1)) && (ph == '0));
    endfunction

    always_comb begin
        if (r_rate < RATE_W'(RATE_MIN)) begin
            rate_eff = RATE_W'(RATE_MIN);
        end else if (r_rate > RATE_W'(RATE_MAX)) begin
            rate_eff = RATE_W'(RATE_MAX);
        end else begin
            rate_eff = r_rate;
        end
    end

    assign km1   = r_k - COUNT_W'(1);
    assign ahead = r_whole - km1;

    assign o_sts.pass      = (rate_eff == RATE_W'(OUT_RATE));
    assign o_sts.interp_go = (r_k != '0) && (r_whole == km1);
    assign o_sts.end_go    = r_last && end_cond(r_whole - r_k, r_phase);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // phase + rate stays below (ADV_MAX_Q+1) periods, so ADV_MAX_Q compares find the carry
    always_comb begin
        adv_sum = RATE_W'(r_phase) + rate_eff;
        adv_q   = '0;
        adv_sub = '0;
        for (int i = 1; i <= ADV_MAX_Q; i++) begin
            if (adv_sum >= RATE_W'(i * OUT_RATE)) begin
                adv_q   = ADV_Q_W'(i);
                adv_sub = RATE_W'(i * OUT_RATE);
            end
        end
    end

    always_comb begin
        acc     = (PROD_W+1)'(r_p0) + (PROD_W+1)'(r_p1);
        acc_abs = acc[PROD_W] ? -acc : acc;
    end

    assign more_interp = !i_cmd.end_sel && (r_adv_whole == km1);
    assign more_end    = r_last && end_cond(r_adv_whole - r_k, r_adv_phase);

    always_comb begin
        q0      = r_prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        q0_back = q0 * QUOT_W'(OUT_RATE);
        rem     = COUNT_W'(r_mag) - q0_back;
        quot    = (rem >= COUNT_W'(OUT_RATE)) ? ({1'b0, q0} + (QUOT_W+1)'(1)) : {1'b0, q0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_W'(RATE_RESET);
        end else if (i_cfg_valid) begin
            r_rate <= i_cfg_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_k     <= '0;
            r_whole <= '0;
            r_phase <= '0;
        end else begin
            if (i_cmd.catch_up && (r_k != '0) && ahead[COUNT_W-1]) begin
                r_whole <= km1;
            end
            if (i_cmd.emit_calc) begin
                r_whole <= r_adv_whole;
                r_phase <= r_adv_phase;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_prev  <= '0;
                    r_k     <= '0;
                    r_whole <= '0;
                    r_phase <= '0;
                end else begin
                    r_prev <= r_cur;
                    r_k    <= r_k + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur  <= i_sample_in;
            r_last <= i_in_last;
        end
        if (i_cmd.start_calc) begin
            r_p0        <= r_prev * $signed({1'b0, PHASE_W'(OUT_RATE) - r_phase});
            r_p1        <= r_cur * $signed({1'b0, r_phase});
            r_adv_whole <= r_whole + COUNT_W'(adv_q);
            r_adv_phase <= PHASE_W'(adv_sum - adv_sub);
        end
        if (i_cmd.sum) begin
            r_mag  <= acc_abs[MAG_W-1:0];
            r_neg  <= acc[PROD_W];
            r_more <= i_cmd.room_next && (more_interp || more_end);
        end
        if (i_cmd.recip) begin
            r_prod <= r_mag * RECIP;
        end
        if (i_cmd.corr) begin
            r_interp <= r_neg ? SAMPLE_W'(-quot) : quot[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_calc || i_cmd.emit_pass) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_calc) begin
            r_out_sample <= i_cmd.end_sel ? r_cur : r_interp;
            r_out_last   <= r_last && !r_more;
        end else if (i_cmd.emit_pass) begin
            r_out_sample <= r_cur;
            r_out_last   <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_out_last   = r_out_last;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < PHASE_W'(OUT_RATE))
        else $error("phase out of range");

    a_clip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_last) |=> (r_k == '0) && (r_whole == '0) && (r_phase == '0))
        else $error("stream state not cleared at end of clip");

    a_more_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sum && !i_cmd.room_next) |=> !r_more)
        else $error("lookahead claims a result past the limit");

endmodule

/* src/linear_interp_resampler_44k1_core.sv */
// Linear interpolation resampler to 44100 Hz, 16-bit mono.
// Pass-through (rate 44100): one result per input request.
// Otherwise N results per request, one six-step pass of the shared
// multiply/reciprocal-divide unit per result.
// Stalls on the output hold the sequence only while the output register is full.
// Synchronous active-low reset: source rate 16000, stream state and output cleared.
module linear_interp_resampler_44k1_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lirs_in_if.sink    i_in,
    lirs_out_if.source o_out,
    lirs_cfg_if.sink   i_cfg
);
    import lirs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    lirs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lirs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_rate   (i_cfg.source_rate),
        .i_sample_in  (i_in.sample_in),
        .i_in_last    (i_in.in_last),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_sample_out (o_out.sample_out),
        .o_out_last   (o_out.out_last),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule
